// ===== sv/gne_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package gne_pkg;

  // grid geometry
  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int COORD_W    = 6;
  localparam int DIM_W      = 7;
  localparam int ADDR_W     = 12;
  localparam int COST_W     = 12;
  localparam int WEIGHT_W   = 4;
  localparam int DIR_W      = 3;
  localparam int CFG_DATA_W = 7;
  localparam int CFG_IDX_W  = 2;

  localparam logic [WEIGHT_W-1:0] WEIGHT_MIN = 4'd1;
  localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = 4'd9;
  localparam logic [8:0]          SQRT2_Q8   = 9'd362;

  typedef enum logic [0:0] {
    ACT_WRITE = 1'b0,
    ACT_QUERY = 1'b1
  } action_t;

  typedef enum logic [DIR_W-1:0] {
    DIR_NONE  = 3'd0,
    DIR_EAST  = 3'd1,
    DIR_SOUTH = 3'd2,
    DIR_WEST  = 3'd3,
    DIR_NORTH = 3'd4
  } dir_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_DIAG   = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_READ,
    B_EVAL,
    B_EMIT
  } back_state_t;

  typedef struct packed {
    logic                action;
    logic [COORD_W-1:0]  cell_x;
    logic [COORD_W-1:0]  cell_y;
    logic                blocked;
    logic [DIR_W-1:0]    one_way;
    logic [WEIGHT_W-1:0] cost_weight;
  } in_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] neighbor_x;
    logic [COORD_W-1:0] neighbor_y;
    logic [COST_W-1:0]  step_cost;
    logic               diagonal_move;
    logic               found;
    logic               last;
    logic               error;
  } out_item_t;

  // one stored grid cell
  typedef struct packed {
    logic                blocked;
    logic [DIR_W-1:0]    dir;
    logic [WEIGHT_W-1:0] weight;
  } cell_t;

  localparam cell_t CELL_RESET = '{blocked: 1'b0, dir: DIR_NONE, weight: WEIGHT_MIN};

  // classified item handed from front to back
  typedef struct packed {
    logic               is_query;
    logic               error;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    cell_t              data;
  } q_item_t;

  // effective grid configuration
  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic             diag_en;
  } cfg_t;

  // clamp a grid dimension to 1..max
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] max_v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > max_v) begin
      r = max_v;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/gne_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gne_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire gne_pkg::q_item_t push_item,
  input  wire logic             pop,
  output gne_pkg::q_item_t      head,
  output logic                  empty,
  output logic                  full
);

  gne_pkg::q_item_t slots [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign head  = slots[rd_ptr];
  assign empty = (count == 2'd0);
  assign full  = (count == 2'd2);

  // two-entry fifo between classification and execution
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

// ===== sv/gne_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gne_front (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire gne_pkg::in_item_t                in_item,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [gne_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [gne_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                             q_full,
  input  wire logic                             clearing,
  output logic                                  push,
  output gne_pkg::q_item_t                      push_item,
  output gne_pkg::cfg_t                         cfg
);

  localparam logic [gne_pkg::DIM_W-1:0] MAX_W = gne_pkg::DIM_W'(gne_pkg::MAX_WIDTH);
  localparam logic [gne_pkg::DIM_W-1:0] MAX_H = gne_pkg::DIM_W'(gne_pkg::MAX_HEIGHT);

  logic                          in_bounds;
  logic [gne_pkg::WEIGHT_W-1:0]  wgt_clamped;
  logic [gne_pkg::DIR_W-1:0]     dir_clean;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full && !clearing;
  assign push      = in_valid && in_ready;

  // configuration registers, held as effective values
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width   <= MAX_W;
      cfg.height  <= MAX_H;
      cfg.diag_en <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gne_pkg::CFG_WIDTH:  cfg.width   <= gne_pkg::clamp_dim(cfg_data, MAX_W);
        gne_pkg::CFG_HEIGHT: cfg.height  <= gne_pkg::clamp_dim(cfg_data, MAX_H);
        gne_pkg::CFG_DIAG:   cfg.diag_en <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // classify: bounds check and sanitize the written cell
  always_comb begin
    in_bounds = ({1'b0, in_item.cell_x} < cfg.width) &&
                ({1'b0, in_item.cell_y} < cfg.height);

    if (in_item.cost_weight < gne_pkg::WEIGHT_MIN) begin
      wgt_clamped = gne_pkg::WEIGHT_MIN;
    end else if (in_item.cost_weight > gne_pkg::WEIGHT_MAX) begin
      wgt_clamped = gne_pkg::WEIGHT_MAX;
    end else begin
      wgt_clamped = in_item.cost_weight;
    end

    if (in_item.one_way <= gne_pkg::DIR_NORTH) begin
      dir_clean = in_item.one_way;
    end else begin
      dir_clean = gne_pkg::DIR_NONE;
    end

    push_item.is_query = (in_item.action == gne_pkg::ACT_QUERY);
    push_item.error    = !in_bounds;
    push_item.x        = in_item.cell_x;
    push_item.y        = in_item.cell_y;
    if (in_item.blocked) begin
      push_item.data.blocked = 1'b1;
      push_item.data.dir     = gne_pkg::DIR_NONE;
      push_item.data.weight  = gne_pkg::WEIGHT_MIN;
    end else begin
      push_item.data.blocked = 1'b0;
      push_item.data.dir     = dir_clean;
      push_item.data.weight  = wgt_clamped;
    end
  end

endmodule

`default_nettype wire

// ===== sv/gne_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gne_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire gne_pkg::cfg_t     cfg,
  input  wire gne_pkg::q_item_t  head,
  input  wire logic              q_empty,
  output logic                   pop,
  output logic                   clearing,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output gne_pkg::out_item_t     out_item
);

  localparam int CELLS = 1 << gne_pkg::ADDR_W;

  // candidate order: east, south, west, north, then the four diagonals
  localparam logic [1:0] CAND_RX [8] = '{2'd2, 2'd1, 2'd0, 2'd1, 2'd2, 2'd0, 2'd0, 2'd2};
  localparam logic [1:0] CAND_RY [8] = '{2'd1, 2'd2, 2'd1, 2'd0, 2'd2, 2'd2, 2'd0, 2'd0};

  gne_pkg::back_state_t state, state_next;

  gne_pkg::cell_t mem [CELLS];
  gne_pkg::cell_t rd_data;
  gne_pkg::cell_t cells [3][3];

  logic [gne_pkg::ADDR_W-1:0]  clr_addr;
  logic [gne_pkg::COORD_W-1:0] qx, qy;
  logic [1:0]                  rdx, rdy, rdx_next, rdy_next;
  logic [1:0]                  tag_x, tag_y;
  logic                        tag_live;
  logic [7:0]                  pend, pend_next;
  logic [7:0]                  mask;

  logic                        mem_we;
  logic [gne_pkg::ADDR_W-1:0]  mem_wa;
  gne_pkg::cell_t              mem_wd;
  logic                        rd_en;
  logic [gne_pkg::ADDR_W-1:0]  rd_addr;
  logic                        start;
  logic                        load_out;
  gne_pkg::out_item_t          out_next;
  logic                        out_free;

  logic [gne_pkg::DIM_W-1:0]   gx [3];
  logic [gne_pkg::DIM_W-1:0]   gy [3];
  logic                        ok_x [3];
  logic                        ok_y [3];
  logic [gne_pkg::DIR_W-1:0]   own;
  logic [2:0]                  sel;
  logic [1:0]                  sx, sy;
  logic [12:0]                 diag_prod;

  assign clearing = (state == gne_pkg::B_CLEAR);
  assign out_free = !out_valid || out_ready;

  // coordinates of the 3x3 window around the queried cell
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      gx[i]   = {1'b0, qx} + gne_pkg::DIM_W'(i) - gne_pkg::DIM_W'(1);
      gy[i]   = {1'b0, qy} + gne_pkg::DIM_W'(i) - gne_pkg::DIM_W'(1);
      ok_x[i] = gx[i] < cfg.width;
      ok_y[i] = gy[i] < cfg.height;
    end
  end

  // passable neighbor mask from the captured window
  always_comb begin
    own = cells[1][1].dir;
    mask[0] = ok_x[2] && ok_y[1] && !cells[1][2].blocked &&
              (own == gne_pkg::DIR_NONE || own == gne_pkg::DIR_EAST) &&
              (cells[1][2].dir == gne_pkg::DIR_NONE || cells[1][2].dir == gne_pkg::DIR_EAST);
    mask[1] = ok_x[1] && ok_y[2] && !cells[2][1].blocked &&
              (own == gne_pkg::DIR_NONE || own == gne_pkg::DIR_SOUTH) &&
              (cells[2][1].dir == gne_pkg::DIR_NONE || cells[2][1].dir == gne_pkg::DIR_SOUTH);
    mask[2] = ok_x[0] && ok_y[1] && !cells[1][0].blocked &&
              (own == gne_pkg::DIR_NONE || own == gne_pkg::DIR_WEST) &&
              (cells[1][0].dir == gne_pkg::DIR_NONE || cells[1][0].dir == gne_pkg::DIR_WEST);
    mask[3] = ok_x[1] && ok_y[0] && !cells[0][1].blocked &&
              (own == gne_pkg::DIR_NONE || own == gne_pkg::DIR_NORTH) &&
              (cells[0][1].dir == gne_pkg::DIR_NONE || cells[0][1].dir == gne_pkg::DIR_NORTH);
    // diagonals: directionless target, no corner cutting
    for (int k = 4; k < 8; k++) begin
      mask[k] = cfg.diag_en && (own == gne_pkg::DIR_NONE) &&
                ok_x[CAND_RX[k]] && ok_y[CAND_RY[k]] &&
                !cells[CAND_RY[k]][CAND_RX[k]].blocked &&
                (cells[CAND_RY[k]][CAND_RX[k]].dir == gne_pkg::DIR_NONE) &&
                !cells[1][CAND_RX[k]].blocked &&
                !cells[CAND_RY[k]][1].blocked;
    end
  end

  // first pending candidate
  always_comb begin
    sel = 3'd0;
    for (int k = 7; k >= 0; k--) begin
      if (pend[k]) begin
        sel = 3'(k);
      end
    end
    sx        = CAND_RX[sel];
    sy        = CAND_RY[sel];
    diag_prod = {9'd0, cells[sy][sx].weight} * {4'd0, gne_pkg::SQRT2_Q8};
  end

  // sequencer: next state and datapath controls
  always_comb begin
    state_next = state;
    pop        = 1'b0;
    mem_we     = 1'b0;
    mem_wa     = clr_addr;
    mem_wd     = gne_pkg::CELL_RESET;
    rd_en      = 1'b0;
    rd_addr    = {gy[rdy][gne_pkg::COORD_W-1:0], gx[rdx][gne_pkg::COORD_W-1:0]};
    start      = 1'b0;
    load_out   = 1'b0;
    out_next   = '0;
    pend_next  = pend;
    rdx_next   = rdx;
    rdy_next   = rdy;

    unique case (state)
      gne_pkg::B_CLEAR: begin
        mem_we = 1'b1;
        if (clr_addr == gne_pkg::ADDR_W'(CELLS - 1)) begin
          state_next = gne_pkg::B_IDLE;
        end
      end
      gne_pkg::B_IDLE: begin
        if (!q_empty && out_free) begin
          pop           = 1'b1;
          out_next.last = 1'b1;
          if (head.error) begin
            load_out       = 1'b1;
            out_next.error = 1'b1;
          end else if (!head.is_query) begin
            load_out = 1'b1;
            mem_we   = 1'b1;
            mem_wa   = {head.y, head.x};
            mem_wd   = head.data;
          end else begin
            start      = 1'b1;
            rdx_next   = 2'd0;
            rdy_next   = 2'd0;
            state_next = gne_pkg::B_READ;
          end
        end
      end
      gne_pkg::B_READ: begin
        if (rdy == 2'd3) begin
          state_next = gne_pkg::B_EVAL;
        end else begin
          rd_en = 1'b1;
          if (rdx == 2'd2) begin
            rdx_next = 2'd0;
            rdy_next = rdy + 2'd1;
          end else begin
            rdx_next = rdx + 2'd1;
          end
        end
      end
      gne_pkg::B_EVAL: begin
        pend_next  = mask;
        state_next = gne_pkg::B_EMIT;
      end
      gne_pkg::B_EMIT: begin
        if (out_free) begin
          load_out = 1'b1;
          if (pend == 8'd0) begin
            out_next.last = 1'b1;
            state_next    = gne_pkg::B_IDLE;
          end else begin
            pend_next              = pend & ~(8'd1 << sel);
            out_next.found         = 1'b1;
            out_next.neighbor_x    = gx[sx][gne_pkg::COORD_W-1:0];
            out_next.neighbor_y    = gy[sy][gne_pkg::COORD_W-1:0];
            out_next.diagonal_move = sel[2];
            if (sel[2]) begin
              out_next.step_cost = diag_prod[gne_pkg::COST_W-1:0];
            end else begin
              out_next.step_cost = {cells[sy][sx].weight, 8'd0};
            end
            out_next.last = (pend_next == 8'd0);
            if (pend_next == 8'd0) begin
              state_next = gne_pkg::B_IDLE;
            end
          end
        end
      end
      default: state_next = gne_pkg::B_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= gne_pkg::B_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
      tag_live  <= 1'b0;
      pend      <= '0;
      rdx       <= 2'd0;
      rdy       <= 2'd0;
    end else begin
      state    <= state_next;
      pend     <= pend_next;
      rdx      <= rdx_next;
      rdy      <= rdy_next;
      tag_live <= rd_en;
      if (state == gne_pkg::B_CLEAR) begin
        clr_addr <= clr_addr + gne_pkg::ADDR_W'(1);
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_item <= out_next;
    end
    if (start) begin
      qx <= head.x;
      qy <= head.y;
    end
    if (rd_en) begin
      tag_x <= rdx;
      tag_y <= rdy;
    end
    if (tag_live) begin
      cells[tag_y][tag_x] <= rd_data;
    end
  end

  // grid store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/grid_neighbor_expander_top.sv =====
// Grid neighbor expander: a 64x64 cell map with per-cell blocked bit,
// one-way direction and weight, answering neighbor queries with move costs.
// Input channel (in_valid/in_ready/in_item) carries writes and queries;
// output channel (out_valid/out_ready/out_item) returns result items, the
// final one of each input marked by last. Config channel (cfg_valid,
// cfg_ready, cfg_index, cfg_data) sets grid width, height and diagonals;
// it is always ready; the user must write it only while the block is
// idle (not enforced). After reset the map is cleared one cell per cycle:
// in_ready is low until all 4096 cells are cleared, then every cell is
// unblocked, directionless, weight 1. An input transfer lands in a
// two-entry queue; the back end takes it once idle with the result
// register free. Writes and out-of-grid items give their single result
// in the cycle after leaving the queue. A query reads its 3x3 window
// through the single map read port (nine reads, then capturing the last),
// evaluates it and issues one result per cycle while out_ready allows,
// 1 to 8 results in all. The result register holds while out_ready is low;
// the back end waits and the queue keeps taking items until it is full.
`timescale 1ns / 1ps
`default_nettype none

module grid_neighbor_expander_top (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire gne_pkg::in_item_t               in_item,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output gne_pkg::out_item_t                   out_item,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [gne_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [gne_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic             q_full;
  logic             q_empty;
  logic             clearing;
  logic             push;
  logic             pop;
  gne_pkg::q_item_t push_item;
  gne_pkg::q_item_t head;
  gne_pkg::cfg_t    cfg;

  // accept, classify and hold configuration
  gne_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .clearing  (clearing),
    .push      (push),
    .push_item (push_item),
    .cfg       (cfg)
  );

  // decoupling queue
  gne_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  // map store and neighbor expansion
  gne_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .head      (head),
    .q_empty   (q_empty),
    .pop       (pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire
